/* hw/rtl/mtfdc_pkg.sv */
package mtfdc_pkg;

    // default sizes of the stores
    localparam int MAX_ITEMS_DEF      = 256;
    localparam int POSITION_SLOTS_DEF = 1024;

    // fixed field widths
    localparam int NUM_W   = 9;
    localparam int ITEM_W  = 8;
    localparam int DEPTH_W = 8;
    localparam int ERR_W   = 2;

    localparam logic [NUM_W-1:0] NUM_RESET = 9'd256;

    typedef logic [ERR_W-1:0] t_err;

    // result error codes
    localparam t_err ERR_OK    = 2'd0;
    localparam t_err ERR_ITEM  = 2'd1;
    localparam t_err ERR_SLOTS = 2'd2;

endpackage

/* hw/rtl/move_to_front_depth_counter_core.sv */
// channel   direction  ports                             transaction
// command   in         start, busy, i_kind, i_item       start high while busy low
// result    out        o_done, o_depth, o_error          o_done high for one cycle
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_data   valid and ready high
//
// an access is paced by the single read port of the count memory: the range sum reads
// tree nodes one at a time and each of the two leaf updates spends a read and a write per
// tree level
// a restart writes one leaf a cycle, then builds each inner node from its two children
// a rejected access gives its result on the cycle after it is taken
// reset leaves the stack empty, so an access before the first restart is rejected
// the result is shown for one cycle only, the receiver cannot stall it
module move_to_front_depth_counter_core
    #(
    parameter int MAX_ITEMS      = mtfdc_pkg::MAX_ITEMS_DEF,
    parameter int POSITION_SLOTS = mtfdc_pkg::POSITION_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [mtfdc_pkg::ITEM_W-1:0]  i_item,
    output logic                          o_done,
    output logic [mtfdc_pkg::DEPTH_W-1:0] o_depth,
    output mtfdc_pkg::t_err               o_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mtfdc_pkg::NUM_W-1:0]   i_cfg_data
);

    import mtfdc_pkg::*;

    localparam int SW  = $clog2(POSITION_SLOTS);
    localparam int TW  = $clog2(2 * POSITION_SLOTS);
    localparam int CW  = $clog2(POSITION_SLOTS + 1);
    localparam int LW  = TW + 1;
    localparam int IAW = $clog2(MAX_ITEMS);

    localparam logic [TW-1:0] LEAF_BASE = TW'(POSITION_SLOTS);
    localparam logic [TW-1:0] LEAF_LAST = TW'(2 * POSITION_SLOTS - 1);
    localparam logic [TW-1:0] ROOT      = TW'(1);
    localparam logic [CW-1:0] SLOTS_C   = CW'(POSITION_SLOTS);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLR_LEAF = 4'd1;
    localparam logic [3:0] ST_NODE_A   = 4'd2;
    localparam logic [3:0] ST_NODE_B   = 4'd3;
    localparam logic [3:0] ST_NODE_C   = 4'd4;
    localparam logic [3:0] ST_SLOT     = 4'd5;
    localparam logic [3:0] ST_SUM_L    = 4'd6;
    localparam logic [3:0] ST_SUM_R    = 4'd7;
    localparam logic [3:0] ST_UPD0     = 4'd8;
    localparam logic [3:0] ST_UPD_A    = 4'd9;
    localparam logic [3:0] ST_UPD_B    = 4'd10;

    logic [3:0]         r_state, n_state;
    logic [NUM_W-1:0]   r_num;
    logic [CW-1:0]      r_live, n_live;
    logic [CW-1:0]      r_next, n_next;
    logic [CW-1:0]      r_n, n_n;
    logic [TW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_acc, n_acc;
    logic [LW-1:0]      r_l, n_l;
    logic [LW-1:0]      r_r, n_r;
    logic [CW-1:0]      r_sum, n_sum;
    logic               r_pend, n_pend;
    logic               r_phase, n_phase;
    logic [SW-1:0]      r_slot, n_slot;
    logic [IAW-1:0]     r_item, n_item;
    logic               r_done, n_done;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    t_err               r_err, n_err;

    logic               t_we;
    logic [TW-1:0]      t_waddr, t_raddr;
    logic [CW-1:0]      t_wdata, t_rdata;
    logic               m_we;
    logic [IAW-1:0]     m_waddr, m_raddr;
    logic [SW-1:0]      m_wdata, m_rdata;

    logic [31:0]        w_n32;
    logic [CW-1:0]      w_n;
    logic [SW-1:0]      w_leaf;
    logic [CW-1:0]      w_acc_sum;
    logic [CW-1:0]      w_up;

    // tree of slot counts, leaves at POSITION_SLOTS + slot
    mtfdc_ram #(
        .WIDTH (CW),
        .DEPTH (2 * POSITION_SLOTS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    // slot held by each item
    mtfdc_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ITEMS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    assign m_raddr     = IAW'(i_item);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_depth     = r_depth;
    assign o_error     = r_err;

    // clamp of the item count taken at restart
    always_comb begin
        w_n32 = 32'(r_num);
        if (w_n32 < 32'd1) begin
            w_n32 = 32'd1;
        end
        if (w_n32 > 32'(MAX_ITEMS)) begin
            w_n32 = 32'(MAX_ITEMS);
        end
        if (w_n32 > 32'(POSITION_SLOTS)) begin
            w_n32 = 32'(POSITION_SLOTS);
        end
        w_n = CW'(w_n32);
    end

    assign w_leaf    = SW'(r_idx - LEAF_BASE);
    assign w_acc_sum = r_sum + (r_pend ? t_rdata : CW'(0));
    assign w_up      = r_acc + t_rdata;

    // sequencer: restart rebuild, range sum, two leaf updates
    always_comb begin
        n_state = r_state;
        n_live  = r_live;
        n_next  = r_next;
        n_n     = r_n;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_l     = r_l;
        n_r     = r_r;
        n_sum   = r_sum;
        n_pend  = r_pend;
        n_phase = r_phase;
        n_slot  = r_slot;
        n_item  = r_item;
        n_done  = 1'b0;
        n_depth = r_depth;
        n_err   = r_err;
        t_we    = 1'b0;
        t_waddr = '0;
        t_wdata = '0;
        t_raddr = '0;
        m_we    = 1'b0;
        m_waddr = '0;
        m_wdata = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (!i_kind) begin
                        n_n     = w_n;
                        n_live  = w_n;
                        n_next  = w_n;
                        n_idx   = LEAF_BASE;
                        n_state = ST_CLR_LEAF;
                    end else if (32'(i_item) >= 32'(r_live)) begin
                        n_done  = 1'b1;
                        n_depth = '0;
                        n_err   = ERR_ITEM;
                    end else if (r_next == SLOTS_C) begin
                        n_done  = 1'b1;
                        n_depth = '0;
                        n_err   = ERR_SLOTS;
                    end else begin
                        n_item  = IAW'(i_item);
                        n_state = ST_SLOT;
                    end
                end
            end

            // one leaf a cycle, with an item entry for each leaf below the item count
            ST_CLR_LEAF: begin
                t_we    = 1'b1;
                t_waddr = r_idx;
                if (CW'(w_leaf) < r_n) begin
                    t_wdata = CW'(1);
                    m_we    = 1'b1;
                    m_waddr = IAW'(w_leaf);
                    m_wdata = SW'(r_n - CW'(1) - CW'(w_leaf));
                end
                if (r_idx == LEAF_LAST) begin
                    n_idx   = LEAF_BASE - TW'(1);
                    n_state = ST_NODE_A;
                end else begin
                    n_idx = r_idx + TW'(1);
                end
            end

            // inner nodes from the bottom up, children read one after the other
            ST_NODE_A: begin
                t_raddr = TW'({r_idx, 1'b0});
                n_state = ST_NODE_B;
            end

            ST_NODE_B: begin
                t_raddr = TW'({r_idx, 1'b1});
                n_acc   = t_rdata;
                n_state = ST_NODE_C;
            end

            ST_NODE_C: begin
                t_we    = 1'b1;
                t_waddr = r_idx;
                t_wdata = r_acc + t_rdata;
                if (r_idx == ROOT) begin
                    n_done  = 1'b1;
                    n_depth = '0;
                    n_err   = ERR_OK;
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx - TW'(1);
                    n_state = ST_NODE_A;
                end
            end

            // slot of the item is back, set up the range above it
            ST_SLOT: begin
                n_slot  = m_rdata;
                n_l     = LW'(m_rdata) + LW'(1) + LW'(POSITION_SLOTS);
                n_r     = LW'(r_next) + LW'(POSITION_SLOTS);
                n_sum   = '0;
                n_pend  = 1'b0;
                n_state = ST_SUM_L;
            end

            // left edge of the range sum
            ST_SUM_L: begin
                n_sum = w_acc_sum;
                if (r_l >= r_r) begin
                    n_pend  = 1'b0;
                    n_state = ST_UPD0;
                end else begin
                    if (r_l[0]) begin
                        t_raddr = TW'(r_l);
                        n_pend  = 1'b1;
                        n_l     = r_l + LW'(1);
                    end else begin
                        n_pend = 1'b0;
                    end
                    n_state = ST_SUM_R;
                end
            end

            // right edge of the range sum, then up one level
            ST_SUM_R: begin
                n_sum = w_acc_sum;
                if (r_r[0]) begin
                    t_raddr = TW'(r_r - LW'(1));
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = ST_SUM_L;
            end

            // clear the old leaf of the item
            ST_UPD0: begin
                t_we    = 1'b1;
                t_waddr = LEAF_BASE + TW'(r_slot);
                t_wdata = '0;
                n_idx   = LEAF_BASE + TW'(r_slot);
                n_acc   = '0;
                n_phase = 1'b0;
                n_state = ST_UPD_A;
            end

            // read the sibling, or finish this leaf update
            ST_UPD_A: begin
                if (r_idx == ROOT) begin
                    if (!r_phase) begin
                        m_we    = 1'b1;
                        m_waddr = r_item;
                        m_wdata = SW'(r_next);
                        t_we    = 1'b1;
                        t_waddr = LEAF_BASE + TW'(r_next);
                        t_wdata = CW'(1);
                        n_idx   = LEAF_BASE + TW'(r_next);
                        n_acc   = CW'(1);
                        n_phase = 1'b1;
                    end else begin
                        n_next  = r_next + CW'(1);
                        n_done  = 1'b1;
                        n_depth = DEPTH_W'(r_sum);
                        n_err   = ERR_OK;
                        n_state = ST_IDLE;
                    end
                end else begin
                    t_raddr = r_idx ^ TW'(1);
                    n_state = ST_UPD_B;
                end
            end

            // parent gets path value plus sibling
            ST_UPD_B: begin
                t_we    = 1'b1;
                t_waddr = r_idx >> 1;
                t_wdata = w_up;
                n_acc   = w_up;
                n_idx   = r_idx >> 1;
                n_state = ST_UPD_A;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_num   <= NUM_RESET;
            r_live  <= '0;
            r_next  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_next  <= n_next;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_num <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_acc   <= n_acc;
        r_l     <= n_l;
        r_r     <= n_r;
        r_sum   <= n_sum;
        r_pend  <= n_pend;
        r_phase <= n_phase;
        r_slot  <= n_slot;
        r_item  <= n_item;
        r_depth <= n_depth;
        r_err   <= n_err;
    end

`ifndef NO_ASSERTIONS
    // a result always comes with the sequencer back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // the free slot pointer never runs past the slot range
    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= SLOTS_C)
        else $error("next slot beyond slot range");

    // an access to an item outside the live range is rejected at once
    a_item_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind && (32'(i_item) >= 32'(r_live)))
        |=> (o_done && (o_error == ERR_ITEM) && (o_depth == '0)))
        else $error("out of range item not rejected");
`endif

endmodule

/* hw/rtl/mtfdc_ram.sv */
module mtfdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
